>>> rtl/byte_level_pretokenizer_defines.svh
// ----------------------------------------------------------------------------
// Byte-level pre-tokenizer: assertion macros
// Shared concurrent assertion forms for the pre-tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_PRETOKENIZER_DEFINES_SVH
`define BYTE_LEVEL_PRETOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pre-tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pre-tokenizer assertion failed");

`endif

>>> rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// Byte-level pre-tokenizer package
// Types, constants and helper functions shared by the pre-tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

    // Largest number of results one input byte can cause.
    localparam int RES_MAX = 5;
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int IDX_W   = $clog2(RES_MAX);

    // Depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Split mode codes; the unused code behaves as whitespace mode.
    localparam logic [1:0] MODE_BYTE_LEVEL = 2'd0;
    localparam logic [1:0] MODE_METASPACE  = 2'd1;
    localparam logic [1:0] MODE_WHITESPACE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_SPLIT_MODE   = 1'b0;
    localparam logic REG_PREFIX_SPACE = 1'b1;

    // Byte values with a meaning of their own.
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] MARK_B0    = 8'hE2;
    localparam logic [7:0] MARK_B1    = 8'h96;
    localparam logic [7:0] MARK_B2    = 8'h81;

    typedef logic [CNT_W-1:0] res_cnt_t;
    typedef logic [IDX_W-1:0] res_idx_t;

    // Configuration register contents.
    typedef struct packed {
        logic [1:0] split_mode;
        logic       prefix_space;
    } cfg_t;

    // All results that one input byte causes.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [RES_MAX-1:0]      starts;
        logic                    has_byte;
        logic                    last_of_text;
        res_cnt_t                cnt;
    } bundle_t;

    // Append one byte to a result bundle.
    function automatic bundle_t push_res(bundle_t l, logic [7:0] b, logic s);
        bundle_t r;
        r = l;
        if (r.cnt < res_cnt_t'(RES_MAX))
        begin
            r.bytes[r.cnt[IDX_W-1:0]]  = b;
            r.starts[r.cnt[IDX_W-1:0]] = s;
            r.cnt = r.cnt + res_cnt_t'(1);
        end
        return r;
    endfunction

    // Append the three bytes of the metaspace mark.
    function automatic bundle_t push_mark(bundle_t l);
        bundle_t r;
        r = push_res(l, MARK_B0, 1'b1);
        r = push_res(r, MARK_B1, 1'b0);
        r = push_res(r, MARK_B2, 1'b0);
        return r;
    endfunction

    // Release the partial mark bytes that were held back.
    function automatic bundle_t push_held(bundle_t l, logic [1:0] held);
        bundle_t r;
        r = l;
        if (held >= 2'd1)
        begin
            r = push_res(r, MARK_B0, 1'b0);
        end
        if (held >= 2'd2)
        begin
            r = push_res(r, MARK_B1, 1'b0);
        end
        return r;
    endfunction

    // Byte-level table: printable bytes map to themselves, the rest to U+0100 up.
    function automatic logic [8:0] byte_code_point(logic [7:0] b);
        logic [8:0] cp;
        if (b <= 8'd32)
        begin
            cp = 9'h100 + {1'b0, b};
        end
        else if (b >= 8'd127 && b <= 8'd160)
        begin
            cp = 9'h121 + ({1'b0, b} - 9'd127);
        end
        else if (b == 8'd173)
        begin
            cp = 9'h143;
        end
        else
        begin
            cp = {1'b0, b};
        end
        return cp;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bpt_regs.sv
// ----------------------------------------------------------------------------
// Pre-tokenizer configuration registers
// APB-style register file holding the split mode and the prefix-space flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output bpt_pkg::cfg_t      cfg
);
    import bpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register write decode on the word address.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_SPLIT_MODE:   cfg_next.split_mode   = pwdata[1:0];
                REG_PREFIX_SPACE: cfg_next.prefix_space = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_mode   <= MODE_WHITESPACE;
            cfg_reg.prefix_space <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data mux.
    always_comb
    begin
        case (paddr[2])
            REG_SPLIT_MODE:   prdata = {30'd0, cfg_reg.split_mode};
            REG_PREFIX_SPACE: prdata = {31'd0, cfg_reg.prefix_space};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/bpt_front.sv
// ----------------------------------------------------------------------------
// Pre-tokenizer front end
// Accepts text bytes, classifies them under the current mode and builds the
// full bundle of results for each byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bpt_pkg::cfg_t cfg,
    input  wire logic          push,
    input  wire logic [7:0]    text_byte,
    input  wire logic          first_of_text,
    input  wire logic          last_of_text,
    input  wire logic          q_full,
    output logic               q_wr,
    output bpt_pkg::bundle_t   q_data
);
    import bpt_pkg::*;

    logic       emitted_reg;
    logic       emitted_next;
    logic [1:0] cont_reg;
    logic [1:0] cont_next;
    logic [1:0] held_reg;
    logic [1:0] held_next;
    logic       gap_reg;
    logic       gap_next;

    logic       accept;
    logic       ea_cur;
    logic [1:0] cont_cur;
    logic [1:0] held_cur;
    logic       gap_cur;
    logic       start;
    logic [8:0] cp;
    bundle_t    res;

    assign accept = push & ~q_full;

    // A new text starts from the text-start state.
    always_comb
    begin
        ea_cur   = first_of_text ? 1'b0 : emitted_reg;
        cont_cur = first_of_text ? 2'd0 : cont_reg;
        held_cur = first_of_text ? 2'd0 : held_reg;
        gap_cur  = first_of_text ? 1'b1 : gap_reg;
    end

    // Classify the byte and build its result bundle.
    always_comb
    begin
        res          = '0;
        res.has_byte = 1'b1;
        cont_next    = cont_cur;
        held_next    = held_cur;
        gap_next     = gap_cur;
        start        = 1'b0;
        cp           = byte_code_point(text_byte);

        case (cfg.split_mode)
            MODE_BYTE_LEVEL:
            begin
                // Trailing bytes of a multibyte character never start a piece.
                if (cont_cur != 2'd0)
                begin
                    cont_next = cont_cur - 2'd1;
                end
                else if (text_byte == BYTE_SPACE)
                begin
                    start = 1'b1;
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    cont_next = 2'd1;
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    cont_next = 2'd2;
                end
                else if (text_byte[7:3] == 5'b11110)
                begin
                    cont_next = 2'd3;
                end

                if (cp < 9'h080)
                begin
                    res = push_res(res, cp[7:0], start);
                end
                else
                begin
                    res = push_res(res, 8'hC0 | {5'd0, cp[8:6]}, start);
                    res = push_res(res, 8'h80 | {2'd0, cp[5:0]}, 1'b0);
                end
            end

            MODE_METASPACE:
            begin
                // Optional mark ahead of a text that does not open with a space.
                if (first_of_text && cfg.prefix_space && text_byte != BYTE_SPACE)
                begin
                    res = push_mark(res);
                end

                if (text_byte == BYTE_SPACE)
                begin
                    res       = push_held(res, held_cur);
                    held_next = 2'd0;
                    res       = push_mark(res);
                end
                else if (held_cur == 2'd2 && text_byte == MARK_B2)
                begin
                    held_next = 2'd0;
                    res       = push_mark(res);
                end
                else if (held_cur == 2'd1 && text_byte == MARK_B1)
                begin
                    held_next = 2'd2;
                end
                else if (text_byte == MARK_B0)
                begin
                    res       = push_held(res, held_cur);
                    held_next = 2'd1;
                end
                else
                begin
                    res       = push_held(res, held_cur);
                    held_next = 2'd0;
                    res       = push_res(res, text_byte, 1'b0);
                end
            end

            default:
            begin
                // Whitespace mode drops tab through carriage return and space.
                if (text_byte == BYTE_SPACE || (text_byte >= 8'd9 && text_byte <= 8'd13))
                begin
                    gap_next = 1'b1;
                end
                else
                begin
                    res      = push_res(res, text_byte, gap_cur);
                    gap_next = 1'b0;
                end
            end
        endcase

        // End of text flushes held bytes or gives a bare end marker.
        if (last_of_text)
        begin
            if (cfg.split_mode == MODE_METASPACE)
            begin
                res = push_held(res, held_next);
            end
            if (res.cnt == res_cnt_t'(0))
            begin
                res.cnt       = res_cnt_t'(1);
                res.bytes[0]  = 8'd0;
                res.starts[0] = 1'b0;
                res.has_byte  = 1'b0;
            end
        end

        // The first byte given in a text always starts a piece.
        if (res.has_byte && !ea_cur)
        begin
            res.starts[0] = 1'b1;
        end
        res.last_of_text = last_of_text;

        emitted_next = ea_cur | (res.has_byte & (res.cnt != res_cnt_t'(0)));

        if (last_of_text)
        begin
            emitted_next = 1'b0;
            cont_next    = 2'd0;
            held_next    = 2'd0;
            gap_next     = 1'b1;
        end
    end

    // Running state advances on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitted_reg <= 1'b0;
            cont_reg    <= 2'd0;
            held_reg    <= 2'd0;
            gap_reg     <= 1'b1;
        end
        else if (accept)
        begin
            emitted_reg <= emitted_next;
            cont_reg    <= cont_next;
            held_reg    <= held_next;
            gap_reg     <= gap_next;
        end
    end

    // Only bundles with at least one result enter the queue.
    assign q_wr   = accept & (res.cnt != res_cnt_t'(0));
    assign q_data = res;

endmodule

`default_nettype wire

>>> rtl/bpt_fifo.sv
// ----------------------------------------------------------------------------
// Pre-tokenizer bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_level_pretokenizer_defines.svh"

module bpt_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire bpt_pkg::bundle_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output bpt_pkg::bundle_t      rd_data,
    output logic                  not_empty
);
    import bpt_pkg::*;

    bundle_t                   mem_reg [FIFO_DEPTH];
    logic    [PTR_W-1:0]       wr_ptr_reg;
    logic    [PTR_W-1:0]       wr_ptr_next;
    logic    [PTR_W-1:0]       rd_ptr_reg;
    logic    [PTR_W-1:0]       rd_ptr_next;
    logic    [FCNT_W-1:0]      count_reg;
    logic    [FCNT_W-1:0]      count_next;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + FCNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - FCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != FCNT_W'(0));

    // The front never writes a full queue and the back never reads an empty one.
    `BPT_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, count_reg != FCNT_W'(FIFO_DEPTH))
    `BPT_ASSERT_IMP(a_no_underflow, clk, rst_n, rd_en, count_reg != FCNT_W'(0))
    `BPT_ASSERT_NEXT(a_count_up, clk, rst_n, wr_en && !rd_en, count_reg == $past(count_reg) + FCNT_W'(1))

endmodule

`default_nettype wire

>>> rtl/bpt_back.sv
// ----------------------------------------------------------------------------
// Pre-tokenizer back end
// Takes result bundles from the queue and hands them out one result a beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_level_pretokenizer_defines.svh"

module bpt_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bpt_pkg::bundle_t q_data,
    input  wire logic             q_not_empty,
    output logic                  q_rd,
    output logic                  empty,
    input  wire logic             pop,
    output logic      [7:0]       out_byte,
    output logic                  has_byte,
    output logic                  piece_start,
    output logic                  last_of_run,
    output logic                  end_of_text
);
    import bpt_pkg::*;

    bundle_t  bundle_reg;
    logic     valid_reg;
    logic     valid_next;
    res_idx_t idx_reg;
    res_idx_t idx_next;
    logic     last_entry;
    logic     take;

    // The current result is the last of its bundle.
    assign last_entry = (res_cnt_t'(idx_reg) == bundle_reg.cnt - res_cnt_t'(1));
    assign take       = pop & valid_reg;

    // Load a new bundle when idle or when the last result of this one leaves.
    assign q_rd = q_not_empty & (~valid_reg | (take & last_entry));

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (q_rd)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (take && last_entry)
        begin
            valid_next = 1'b0;
            idx_next   = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + res_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            bundle_reg <= q_data;
        end
    end

    // Result ports come straight from the held bundle.
    assign empty       = ~valid_reg;
    assign out_byte    = bundle_reg.bytes[idx_reg];
    assign has_byte    = bundle_reg.has_byte;
    assign piece_start = bundle_reg.starts[idx_reg];
    assign last_of_run = last_entry;
    assign end_of_text = last_entry & bundle_reg.last_of_text;

    `BPT_ASSERT_IMP(a_idx_in_range, clk, rst_n, valid_reg, res_cnt_t'(idx_reg) < bundle_reg.cnt)
    `BPT_ASSERT_NEXT(a_drain_to_empty, clk, rst_n, take && last_entry && !q_not_empty, empty)

endmodule

`default_nettype wire

>>> rtl/byte_level_pretokenizer.sv
// ----------------------------------------------------------------------------
// Byte-level pre-tokenizer
// Text bytes in, pre-token bytes out, with the first byte of each piece flagged.
// ----------------------------------------------------------------------------
// The block accepts one text byte per clock while full is low; each byte is
// classified and turned into its whole group of zero to five results in the
// cycle it is accepted, and a group that is not empty waits in a four-entry
// queue. The back end hands out one result per clock while pop is high, and
// the sustained rate is one input byte per cycle as long as pop stays high and
// no byte gives more than one result. With the queue and the back end idle, a
// byte's group is written into the queue, then loaded into the back end's
// bundle register, from which its first result drives the result ports.
// Write the configuration registers only while no text is in flight.
`default_nettype none

module byte_level_pretokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        first_of_text,
    input  wire logic        last_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic      [7:0]  out_byte,
    output logic             has_byte,
    output logic             piece_start,
    output logic             last_of_run,
    output logic             end_of_text
);
    import bpt_pkg::*;

    cfg_t    cfg;
    logic    q_wr;
    bundle_t q_wr_data;
    logic    q_full;
    logic    q_rd;
    bundle_t q_rd_data;
    logic    q_not_empty;

    // Configuration registers.
    bpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: classify each byte into a bundle of results.
    bpt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .push          (push),
        .text_byte     (text_byte),
        .first_of_text (first_of_text),
        .last_of_text  (last_of_text),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_data        (q_wr_data)
    );

    // Queue of bundles between the two halves.
    bpt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    // Back end: one result per beat.
    bpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rd_data),
        .q_not_empty (q_not_empty),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .piece_start (piece_start),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text)
    );

    assign full = q_full;

endmodule

`default_nettype wire
